### sv/gpd_pkg.sv
// Shared types, constants and helpers for the gamepad response frame decoder.
// No dependencies; used by gpd_core and the top level.
package gpd_pkg;

  // Response ID bytes
  localparam logic [7:0] IdDigital = 8'h41;
  localparam logic [7:0] IdAnalog  = 8'h73;

  // Stick sum reported for a digital frame (both axes centered)
  localparam logic [7:0] CenterSum = 8'd100;

  // Stick scale factor: x * 101 >> 8 maps 0..255 to 0..100
  localparam logic [6:0] ScaleMul = 7'd101;

  // Byte position codes
  localparam int unsigned PosW = 4;
  localparam logic [PosW-1:0] PosId     = 4'd1;
  localparam logic [PosW-1:0] PosBtn0   = 4'd3;
  localparam logic [PosW-1:0] PosBtn1   = 4'd4;
  localparam logic [PosW-1:0] PosRh     = 4'd5;
  localparam logic [PosW-1:0] PosRv     = 4'd6;
  localparam logic [PosW-1:0] PosLh     = 4'd7;
  localparam logic [PosW-1:0] PosLast   = 4'd8;
  localparam logic [PosW-1:0] PosWait   = 4'd9;

  // Status codes
  localparam logic [1:0] StatAnalog  = 2'd0;
  localparam logic [1:0] StatDigital = 2'd1;
  localparam logic [1:0] StatInvalid = 2'd2;

  // One decoded frame, status kept apart from the data fields
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] buttons_first;
    logic [7:0] buttons_second;
    logic [7:0] vertical_sum;
    logic [7:0] horizontal_sum;
    logic [6:0] right_vertical;
    logic [6:0] right_horizontal;
  } result_t;

  // Scale one stick byte to 0..100
  function automatic logic [6:0] scale_axis(input logic [7:0] x);
    logic [14:0] prod;
    prod = 15'(x) * 15'(ScaleMul);
    return prod[14:8];
  endfunction

endpackage

### sv/gpd_core.sv
// Frame tracking, byte capture and frame decision of the gamepad response decoder.
// Depends on gpd_pkg; the caller supplies the registered input byte and a step strobe.
module gpd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_start_i,
  output logic             res_vld_o,
  output gpd_pkg::result_t res_o
);

  logic [gpd_pkg::PosW-1:0] pos_q, pos_d, pos_eff;
  logic [7:0] id_q, id_d;
  logic [7:0] btn0_raw_q, btn0_raw_d, btn1_raw_q, btn1_raw_d;
  logic [6:0] rh_q, rh_d, rv_q, rv_d, lh_q, lh_d;
  logic [7:0] held_btn0_q, held_btn0_d, held_btn1_q, held_btn1_d;
  logic [7:0] held_vsum_q, held_vsum_d, held_hsum_q, held_hsum_d;
  logic [6:0] held_rv_q, held_rv_d, held_rh_q, held_rh_d;
  logic [6:0] scaled;
  logic [1:0] status;
  logic       last_beat;

  // Scale each stick byte as it arrives; one multiplier serves all four
  assign scaled  = gpd_pkg::scale_axis(rx_byte_i);
  assign pos_eff = frame_start_i ? '0 : pos_q;
  assign last_beat = step_i && (pos_eff == gpd_pkg::PosLast);

  // Capture bytes and decide the frame at the last byte
  always_comb begin
    pos_d       = pos_q;
    id_d        = id_q;
    btn0_raw_d  = btn0_raw_q;
    btn1_raw_d  = btn1_raw_q;
    rh_d        = rh_q;
    rv_d        = rv_q;
    lh_d        = lh_q;
    held_btn0_d = held_btn0_q;
    held_btn1_d = held_btn1_q;
    held_vsum_d = held_vsum_q;
    held_hsum_d = held_hsum_q;
    held_rv_d   = held_rv_q;
    held_rh_d   = held_rh_q;
    status      = gpd_pkg::StatInvalid;
    if (step_i && (pos_eff < gpd_pkg::PosWait)) begin
      pos_d = pos_eff + 1'b1;
      case (pos_eff)
        gpd_pkg::PosId:   id_d       = rx_byte_i;
        gpd_pkg::PosBtn0: btn0_raw_d = rx_byte_i;
        gpd_pkg::PosBtn1: btn1_raw_d = rx_byte_i;
        gpd_pkg::PosRh:   rh_d       = scaled;
        gpd_pkg::PosRv:   rv_d       = scaled;
        gpd_pkg::PosLh:   lh_d       = scaled;
        gpd_pkg::PosLast: begin
          pos_d = gpd_pkg::PosWait;
          if (id_q == gpd_pkg::IdAnalog) begin
            held_btn0_d = ~btn0_raw_q;
            held_btn1_d = ~btn1_raw_q;
            held_vsum_d = {1'b0, scaled} + {1'b0, rv_q};
            held_hsum_d = {1'b0, lh_q} + {1'b0, rh_q};
            held_rv_d   = rv_q;
            held_rh_d   = rh_q;
            status      = gpd_pkg::StatAnalog;
          end else if (id_q == gpd_pkg::IdDigital) begin
            held_btn0_d = ~btn0_raw_q;
            held_btn1_d = ~btn1_raw_q;
            held_vsum_d = gpd_pkg::CenterSum;
            held_hsum_d = gpd_pkg::CenterSum;
            status      = gpd_pkg::StatDigital;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= gpd_pkg::PosWait;
      id_q        <= '0;
      btn0_raw_q  <= '0;
      btn1_raw_q  <= '0;
      rh_q        <= '0;
      rv_q        <= '0;
      lh_q        <= '0;
      held_btn0_q <= '0;
      held_btn1_q <= '0;
      held_vsum_q <= '0;
      held_hsum_q <= '0;
      held_rv_q   <= '0;
      held_rh_q   <= '0;
    end else begin
      pos_q       <= pos_d;
      id_q        <= id_d;
      btn0_raw_q  <= btn0_raw_d;
      btn1_raw_q  <= btn1_raw_d;
      rh_q        <= rh_d;
      rv_q        <= rv_d;
      lh_q        <= lh_d;
      held_btn0_q <= held_btn0_d;
      held_btn1_q <= held_btn1_d;
      held_vsum_q <= held_vsum_d;
      held_hsum_q <= held_hsum_d;
      held_rv_q   <= held_rv_d;
      held_rh_q   <= held_rh_d;
    end
  end

  // Report the updated held values with the frame status
  assign res_vld_o               = last_beat;
  assign res_o.status            = status;
  assign res_o.buttons_first     = held_btn0_d;
  assign res_o.buttons_second    = held_btn1_d;
  assign res_o.vertical_sum      = held_vsum_d;
  assign res_o.horizontal_sum    = held_hsum_d;
  assign res_o.right_vertical    = held_rv_d;
  assign res_o.right_horizontal  = held_rh_d;

endmodule

### sv/gamepad_response_frame_decoder_top.sv
// Gamepad poll response frame decoder, top level with stream handshakes.
// Depends on gpd_pkg and gpd_core.
//
// Usage:
//   The slave channel takes one response byte per beat: s_axis_tdata carries
//   the byte, s_axis_tuser[0] marks byte 0 of a new nine-byte response.
//   Bytes before any start or after byte 8 are dropped. A start in the middle
//   of a response restarts it. At byte 8 the master channel delivers one beat
//   with the decoded frame: m_axis_tuser holds the status (analog, digital or
//   invalid ID) and m_axis_tdata the held buttons, stick sums and right stick.
//   An invalid ID leaves the held values as they were.
//   Byte 8 is held in the input register, then the core decides it into the
//   result register, which drives the result beat. Throughput is one byte per
//   cycle while the result register is free or being emptied.
//   When the receiver stalls with a result pending, no byte advances through
//   the core: the block still takes one more byte if its input register is
//   empty, then holds s_axis_tready low until the result is taken.
//   Reset clears all held values to zero and waits for a start flag.
module gamepad_response_frame_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] buttons_first, [15:8] buttons_second, [23:16] vertical_sum,
  // [31:24] horizontal_sum, [38:32] right_vertical, [45:39] right_horizontal,
  // [47:46] zero
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_byte_q;
  logic             in_start_q;
  logic             out_vld_q, out_vld_d;
  gpd_pkg::result_t out_res_q;
  logic             adv;
  logic             res_vld;
  gpd_pkg::result_t res;

  // Advance when the result register is free or being emptied
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;
  assign out_vld_d     = adv ? res_vld : out_vld_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
  end

  gpd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_vld_q && adv),
    .rx_byte_i     (in_byte_q),
    .frame_start_i (in_start_q),
    .res_vld_o     (res_vld),
    .res_o         (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.right_horizontal,
                          out_res_q.right_vertical,
                          out_res_q.horizontal_sum,
                          out_res_q.vertical_sum,
                          out_res_q.buttons_second,
                          out_res_q.buttons_first};

endmodule

### sv/gpd_checker.sv
// Port-level checks for the gamepad response frame decoder.
// Depends on gpd_pkg and the top level's ports; attached by the bind below.
module gpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // Status is analog, digital or invalid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == gpd_pkg::StatAnalog ||
                       m_axis_tuser == gpd_pkg::StatDigital ||
                       m_axis_tuser == gpd_pkg::StatInvalid))
    else $error("unknown status code");

  // Digital frame reports centered sums
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == gpd_pkg::StatDigital |->
      m_axis_tdata[23:16] == gpd_pkg::CenterSum &&
      m_axis_tdata[31:24] == gpd_pkg::CenterSum)
    else $error("digital frame sums not centered");

  // Held stick values stay in range and padding is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[38:32] <= 7'd100 && m_axis_tdata[45:39] <= 7'd100 &&
      m_axis_tdata[23:16] <= 8'd200 && m_axis_tdata[31:24] <= 8'd200 &&
      m_axis_tdata[47:46] == 2'b00)
    else $error("stick value out of range");

endmodule

bind gamepad_response_frame_decoder_top gpd_checker u_gpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### dv/testbench.sv
// Self-checking testbench for the gamepad response frame decoder top level.
// Depends on gpd_pkg and gamepad_response_frame_decoder_top; walks a directed table,
// then random frames under random idling on both sides, checked by a decoder model.
`timescale 1ns / 100ps

module testbench;

  localparam int ItemTarget   = 400;
  localparam int LongHold     = 200;
  localparam int DrainCycles  = 2000;
  localparam int TailCycles   = 8;
  localparam int MaxShown     = 10;
  localparam int TimeoutNs    = 3_000_000;
  localparam gpd_pkg::result_t NoRes = '0;

  // One directed beat, with an optional typed-in decoded frame
  typedef struct packed {
    logic [7:0]       rx;
    logic             start;
    logic             fixed;
    gpd_pkg::result_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic [0:0]  s_axis_tuser;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] buttons_first, [15:8] buttons_second, [23:16] vertical_sum,
  // [31:24] horizontal_sum, [38:32] right_vertical, [45:39] right_horizontal, [47:46] zero
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;   // [1:0] status

  // Typed expectation travelling with the current beat
  logic             beat_fixed_vld;
  gpd_pkg::result_t beat_fixed;

  // Decoder model state
  logic [3:0]  frame_pos;
  logic [7:0]  frame_id;
  logic [7:0]  raw_bytes [6];
  logic [7:0]  held_btn [2];
  logic [7:0]  held_sum [2];
  logic [6:0]  held_rs [2];

  gpd_pkg::result_t decoded_q [$];

  int fail_count;
  int results_seen;
  int beats_taken;
  int in_stall_cycles;
  int n_analog;
  int n_digital;
  int n_bad_id;
  int long_holds;
  bit burst;
  bit rcv_calm;
  bit long_hold_req;

  gamepad_response_frame_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Map a stick byte to 0..100
  function automatic logic [6:0] stick_percent(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'(gpd_pkg::ScaleMul);
    return prod[14:8];
  endfunction

  // Advance the decoder model by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic start,
                             output logic got, output gpd_pkg::result_t res);
    logic [3:0] pos;
    logic [6:0] s5, s6, s7, s8;
    got = 1'b0;
    res = NoRes;
    if (start) frame_pos = 4'd0;
    pos = frame_pos;
    if (pos < gpd_pkg::PosWait) begin
      if (pos == gpd_pkg::PosId) frame_id = b;
      else if (pos >= gpd_pkg::PosBtn0 && pos <= gpd_pkg::PosLh)
        raw_bytes[3'(pos - gpd_pkg::PosBtn0)] = b;
      if (pos < gpd_pkg::PosLast) begin
        frame_pos = pos + 4'd1;
      end else begin
        // Last byte: decide the frame
        raw_bytes[5] = b;
        frame_pos = gpd_pkg::PosWait;
        if (frame_id == gpd_pkg::IdAnalog || frame_id == gpd_pkg::IdDigital) begin
          held_btn[0] = ~raw_bytes[0];
          held_btn[1] = ~raw_bytes[1];
          if (frame_id == gpd_pkg::IdAnalog) begin
            s5 = stick_percent(raw_bytes[2]);
            s6 = stick_percent(raw_bytes[3]);
            s7 = stick_percent(raw_bytes[4]);
            s8 = stick_percent(raw_bytes[5]);
            held_sum[0] = 8'(s8) + 8'(s6);
            held_sum[1] = 8'(s7) + 8'(s5);
            held_rs[0] = s6;
            held_rs[1] = s5;
            res.status = gpd_pkg::StatAnalog;
            n_analog++;
          end else begin
            held_sum[0] = gpd_pkg::CenterSum;
            held_sum[1] = gpd_pkg::CenterSum;
            res.status = gpd_pkg::StatDigital;
            n_digital++;
          end
        end else begin
          res.status = gpd_pkg::StatInvalid;
          n_bad_id++;
        end
        res.buttons_first    = held_btn[0];
        res.buttons_second   = held_btn[1];
        res.vertical_sum     = held_sum[0];
        res.horizontal_sum   = held_sum[1];
        res.right_vertical   = held_rs[0];
        res.right_horizontal = held_rs[1];
        got = 1'b1;
      end
    end
  endtask

  function automatic gpd_pkg::result_t mk_res(input logic [1:0] st, input logic [7:0] bf,
                                              input logic [7:0] bs, input logic [7:0] vs,
                                              input logic [7:0] hs, input logic [6:0] rv,
                                              input logic [6:0] rh);
    gpd_pkg::result_t r;
    r.status           = st;
    r.buttons_first    = bf;
    r.buttons_second   = bs;
    r.vertical_sum     = vs;
    r.horizontal_sum   = hs;
    r.right_vertical   = rv;
    r.right_horizontal = rh;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic [7:0] rx, input logic start,
                                       input logic fixed, input gpd_pkg::result_t res);
    stim_row_t row;
    row.rx    = rx;
    row.start = start;
    row.fixed = fixed;
    row.res   = res;
    return row;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxShown) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act)
      note_failure($sformatf("frame %0d %s: expected %0d, got %0d", idx, name, exp, act));
  endtask

  // Nonzero idle length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 55) return 0;
    return gap_len();
  endfunction

  // Random byte leaning on the extremes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    else if (r == 1) return 8'hFF;
    else return 8'($urandom_range(0, 255));
  endfunction

  // Offer one beat after an optional gap, hold it until taken
  task automatic send_beat(input logic [7:0] b, input logic start,
                           input logic fixed, input gpd_pkg::result_t res);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid  <= 1'b1;
    s_axis_tdata   <= b;
    s_axis_tuser   <= start;
    beat_fixed_vld <= fixed;
    beat_fixed     <= res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly well-formed responses, some broken ones and some noise
  task automatic send_random_frame();
    int r;
    int n;
    logic [7:0] id;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      n = $urandom_range(0, 9);
      id = (n < 4) ? gpd_pkg::IdAnalog : (n < 7) ? gpd_pkg::IdDigital : pick_byte();
      send_beat(pick_byte(), 1'b1, 1'b0, NoRes);
      send_beat(id, 1'b0, 1'b0, NoRes);
      repeat (7) send_beat(pick_byte(), 1'b0, 1'b0, NoRes);
      // trailing bytes past the end of the response
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 3)) send_beat(pick_byte(), 1'b0, 1'b0, NoRes);
    end else if (r < 90) begin
      // cut short; the next start restarts it
      send_beat(pick_byte(), 1'b1, 1'b0, NoRes);
      send_beat($urandom_range(0, 1) ? gpd_pkg::IdAnalog : gpd_pkg::IdDigital,
                1'b0, 1'b0, NoRes);
      repeat ($urandom_range(0, 6)) send_beat(pick_byte(), 1'b0, 1'b0, NoRes);
    end else if (r < 95) begin
      repeat ($urandom_range(1, 3)) send_beat(pick_byte(), 1'b0, 1'b0, NoRes);
    end else begin
      repeat ($urandom_range(1, 12))
        send_beat(pick_byte(), $urandom_range(0, 3) == 0, 1'b0, NoRes);
    end
  endtask

  // Check delivered frames, then feed accepted bytes to the model
  always @(posedge clk_i) begin : monitor
    logic             got;
    gpd_pkg::result_t pred;
    gpd_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          note_failure($sformatf("unexpected frame: tuser %0d tdata %h",
                                 m_axis_tuser, m_axis_tdata));
        end else begin
          want = decoded_q.pop_front();
          check_field("status", results_seen, 8'(want.status), 8'(m_axis_tuser));
          check_field("buttons_first", results_seen, want.buttons_first, m_axis_tdata[7:0]);
          check_field("buttons_second", results_seen, want.buttons_second,
                      m_axis_tdata[15:8]);
          check_field("vertical_sum", results_seen, want.vertical_sum, m_axis_tdata[23:16]);
          check_field("horizontal_sum", results_seen, want.horizontal_sum,
                      m_axis_tdata[31:24]);
          check_field("right_vertical", results_seen, 8'(want.right_vertical),
                      8'(m_axis_tdata[38:32]));
          check_field("right_horizontal", results_seen, 8'(want.right_horizontal),
                      8'(m_axis_tdata[45:39]));
          check_field("pad", results_seen, 8'd0, 8'(m_axis_tdata[47:46]));
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beats_taken++;
        decode_byte(s_axis_tdata, s_axis_tuser[0], got, pred);
        if (got) decoded_q.push_back(beat_fixed_vld ? beat_fixed : pred);
      end else if (s_axis_tvalid) begin
        in_stall_cycles++;
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        hold_left = LongHold - 1;
        m_axis_tready <= 1'b0;
      end else if (!rcv_calm && $urandom_range(0, 3) == 0) begin
        hold_left = gap_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #(TimeoutNs);
    $display("Timeout: %0d frames still expected", decoded_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    stim_row_t tab [$];
    int frame_no;
    int wait_cnt;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tuser   = 1'b0;
    beat_fixed_vld = 1'b0;
    beat_fixed     = NoRes;
    burst          = 1'b0;
    rcv_calm       = 1'b0;
    long_hold_req  = 1'b0;
    frame_pos      = gpd_pkg::PosWait;
    frame_id       = 8'h00;
    foreach (raw_bytes[i]) raw_bytes[i] = 8'h00;
    held_btn[0] = 8'h00;
    held_btn[1] = 8'h00;
    held_sum[0] = 8'h00;
    held_sum[1] = 8'h00;
    held_rs[0]  = 7'h00;
    held_rs[1]  = 7'h00;

    // Directed table
    // restart right after byte 0: partial frame dropped
    tab.push_back(mk_row(8'hFF, 1'b1, 1'b0, NoRes));
    // analog frame, sticks at full scale
    tab.push_back(mk_row(8'hFF, 1'b1, 1'b0, NoRes));
    tab.push_back(mk_row(gpd_pkg::IdAnalog, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h5A, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hFF, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hFF, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hFF, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hFF, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hFF, 1'b0, 1'b1,
                         mk_res(gpd_pkg::StatAnalog, 8'hFF, 8'h00, 8'd200, 8'd200,
                                7'd100, 7'd100)));
    // digital frame: sums centered, right stick held
    tab.push_back(mk_row(8'h00, 1'b1, 1'b0, NoRes));
    tab.push_back(mk_row(gpd_pkg::IdDigital, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hFF, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b1,
                         mk_res(gpd_pkg::StatDigital, 8'h00, 8'hFF, gpd_pkg::CenterSum,
                                gpd_pkg::CenterSum, 7'd100, 7'd100)));
    // bad id: every held value stays
    tab.push_back(mk_row(8'hFF, 1'b1, 1'b0, NoRes));
    tab.push_back(mk_row(8'h00, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hFF, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h12, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h34, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h56, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h78, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'h9A, 1'b0, 1'b0, NoRes));
    tab.push_back(mk_row(8'hBC, 1'b0, 1'b1,
                         mk_res(gpd_pkg::StatInvalid, 8'h00, 8'hFF, gpd_pkg::CenterSum,
                                gpd_pkg::CenterSum, 7'd100, 7'd100)));
    // byte past the end while waiting: dropped
    tab.push_back(mk_row(8'hA5, 1'b0, 1'b0, NoRes));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (tab[i]) send_beat(tab[i].rx, tab[i].start, tab[i].fixed, tab[i].res);

    // Random frames
    frame_no = 0;
    while (beats_taken < ItemTarget) begin
      // long receiver hold-off while the sender keeps streaming
      if (frame_no == 8) long_hold_req = 1'b1;
      burst = (frame_no >= 8 && frame_no < 12) || $urandom_range(0, 9) == 0;
      rcv_calm = $urandom_range(0, 7) == 0;
      // sender waits for every outstanding frame
      if (frame_no == 30) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk_i);
      end
      send_random_frame();
      frame_no++;
    end

    // Drain
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (decoded_q.size() != 0 && wait_cnt < DrainCycles) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (decoded_q.size() != 0)
      note_failure($sformatf("%0d frames never delivered", decoded_q.size()));

    $display("Covered %0d accepted bytes and %0d delivered frames", beats_taken, results_seen);
    $display("(%0d analog, %0d digital, %0d bad id); input held off %0d cycles over %0d %s",
             n_analog, n_digital, n_bad_id, in_stall_cycles, long_holds,
             "long receiver hold-off(s).");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gpd_pkg.sv
sv/gpd_core.sv
sv/gamepad_response_frame_decoder_top.sv
sv/gpd_checker.sv
dv/testbench.sv
